>>> rtl/core/segw_pkg.sv
// Package with the beat types, constants and register indexes of the segment grid cell walk.
package segw_pkg;

    localparam int GRID_MAX = 16;
    localparam int MAX_RES  = 2 * GRID_MAX - 1;
    localparam int STEP_CAP = 4 * MAX_RES;

    localparam logic [1:0] CFG_CELL_LOG2 = 2'd0;
    localparam logic [1:0] CFG_GRID_W    = 2'd1;
    localparam logic [1:0] CFG_GRID_H    = 2'd2;

    localparam logic [3:0] CELL_LOG2_MIN = 4'd8;
    localparam logic [3:0] CELL_LOG2_MAX = 4'd12;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
    } t_seg_in;

    typedef struct packed {
        logic [3:0] cell_col;
        logic [3:0] cell_row;
        logic       hit;
        logic       last;
    } t_cell_out;

endpackage

>>> rtl/core/segment_grid_cell_walk.sv
// Top level of the segment grid cell walk: sequencer, restoring divider and DDA step unit.
// A segment inside one cell goes straight to the closing state; a vertical segment walks its
// column row by row; a sloped segment runs the divider, the saturate, multiply and add setup
// states, at most 124 DDA steps (each held while the output stalls) and the closing state.
// Throughput: one segment at a time; input stall stays high until the final beat is loaded.
// Reset (synchronous, active low) returns the registers to 8/16/16 and empties the output.
module segment_grid_cell_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [4:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  segw_pkg::t_seg_in   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output segw_pkg::t_cell_out o_out_data
);
    import segw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_SAT, ST_MUL, ST_ADD, ST_WALK, ST_VERT, ST_FIN
    } t_state;

    t_state r_state;

    // Configuration registers, kept raw; the walk uses their clamped values.
    logic [3:0] r_cfg_s;
    logic [4:0] r_cfg_w;
    logic [4:0] r_cfg_h;
    logic [3:0] s_eff;
    logic [4:0] gw;
    logic [4:0] gh;

    // Walk state. Cell indices are signed because the DDA may step below row zero.
    logic [15:0]        r_sy;
    logic [7:0]         r_ixt;
    logic [7:0]         r_iyt;
    logic [7:0]         r_hi;
    logic signed [10:0] r_ix;
    logic signed [10:0] r_iy;
    logic [15:0]        r_dx;
    logic [15:0]        r_rem;
    logic [32:0]        r_quo;
    logic [5:0]         r_div_cnt;
    logic               r_neg;
    logic signed [31:0] r_d;
    logic [12:0]        r_w;
    logic signed [47:0] r_prod;
    logic signed [47:0] r_yn;
    logic signed [47:0] r_ys;
    logic signed [47:0] r_ye;
    logic [4:0]         r_cnt;
    logic [6:0]         r_steps;

    // One cell is held back so that the final beat can carry last.
    logic       r_pend;
    logic [3:0] r_pc;
    logic [3:0] r_pr;

    logic      r_out_valid;
    t_cell_out r_out;

    assign s_eff = (r_cfg_s < CELL_LOG2_MIN) ? CELL_LOG2_MIN :
                   (r_cfg_s > CELL_LOG2_MAX) ? CELL_LOG2_MAX : r_cfg_s;
    assign gw = (r_cfg_w == 5'd0) ? 5'd1 : (r_cfg_w > 5'(GRID_MAX)) ? 5'(GRID_MAX) : r_cfg_w;
    assign gh = (r_cfg_h == 5'd0) ? 5'd1 : (r_cfg_h > 5'(GRID_MAX)) ? 5'(GRID_MAX) : r_cfg_h;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The output register can take a new beat when it is empty or being drained now.
    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // Accept-side decode. Endpoints are ordered by x for the sloped case.
    logic [4:0]  sh16;
    logic [12:0] cell13;
    logic [7:0]  a_ixf, a_iyf, a_ixt, a_iyt;
    logic        swap;
    logic [15:0] ax, ay, bx, by;
    logic [16:0] dy_s;
    logic [15:0] dy_mag;

    assign sh16   = {1'b0, s_eff} + 5'd16;
    assign cell13 = 13'd1 << s_eff;
    assign a_ixf  = 8'(i_in_data.start_x >> s_eff);
    assign a_iyf  = 8'(i_in_data.start_y >> s_eff);
    assign a_ixt  = 8'(i_in_data.end_x >> s_eff);
    assign a_iyt  = 8'(i_in_data.end_y >> s_eff);
    assign swap   = i_in_data.start_x > i_in_data.end_x;
    assign ax     = swap ? i_in_data.end_x   : i_in_data.start_x;
    assign ay     = swap ? i_in_data.end_y   : i_in_data.start_y;
    assign bx     = swap ? i_in_data.start_x : i_in_data.end_x;
    assign by     = swap ? i_in_data.start_y : i_in_data.end_y;
    assign dy_s   = {1'b0, by} - {1'b0, ay};
    assign dy_mag = dy_s[16] ? 16'(-dy_s) : dy_s[15:0];

    // One restoring divider step per cycle.
    logic [16:0] trial;
    logic        q_bit;
    assign trial = {r_rem, r_quo[32]};
    assign q_bit = trial >= {1'b0, r_dx};

    // Saturated, signed slope.
    logic [31:0] d_mag;
    assign d_mag = (r_quo > 33'h07FFFFFFF) ? 32'h7FFFFFFF : r_quo[31:0];

    logic signed [45:0] prod_c;
    assign prod_c = r_d * $signed({1'b0, r_w});

    // DDA step unit: one right, up or down step per cycle while the output register is free.
    logic signed [47:0] cext;
    logic signed [47:0] d_cell;
    logic signed [47:0] ys_init;
    logic               in_row;
    logic               go_up;
    logic signed [10:0] n_ix, n_iy;
    logic signed [47:0] n_yn, n_ys, n_ye;
    logic               put_ok;
    logic [4:0]         n_cnt;
    logic [6:0]         n_steps;
    logic               cont;

    assign cext    = 48'sd1 <<< sh16;
    assign d_cell  = {{16{r_d[31]}}, r_d} <<< s_eff;
    assign ys_init = {40'd0, r_iy[7:0]} <<< sh16;
    assign in_row  = (r_ys <= r_yn) && (r_yn < r_ye);
    assign go_up   = r_yn < r_ys;

    always_comb begin
        n_ix = r_ix;
        n_iy = r_iy;
        n_yn = r_yn;
        n_ys = r_ys;
        n_ye = r_ye;
        if (in_row) begin
            n_ix = r_ix + 11'sd1;
            n_yn = r_yn + d_cell;
        end else if (go_up) begin
            n_iy = r_iy - 11'sd1;
            n_ye = r_ys;
            n_ys = r_ys - cext;
        end else begin
            n_iy = r_iy + 11'sd1;
            n_ys = r_ye;
            n_ye = r_ye + cext;
        end
    end

    logic n_in_grid;
    assign n_in_grid = (n_ix >= 0) && (n_iy >= 0) &&
                       (n_ix < $signed({6'd0, gw})) && (n_iy < $signed({6'd0, gh}));
    assign put_ok  = n_in_grid && (r_cnt < 5'(MAX_RES));
    assign n_cnt   = r_cnt + 5'(put_ok);
    assign n_steps = r_steps + 7'd1;
    assign cont    = ((n_ix != $signed({3'd0, r_ixt})) || (n_iy != $signed({3'd0, r_iyt}))) &&
                     n_in_grid && (n_cnt < 5'(MAX_RES)) && (n_steps < 7'(STEP_CAP));

    // Vertical column walk: rows from the lower end upward.
    logic v_more;
    logic v_put;
    assign v_more = (r_iy < $signed({6'd0, gh})) && (r_iy <= $signed({3'd0, r_hi}));
    assign v_put  = (r_cnt < 5'(MAX_RES));

    // The output register is loaded in this cycle; otherwise it keeps its beat while stalled.
    logic load_out;
    always_comb begin
        case (r_state)
            ST_WALK: load_out = out_free && put_ok && r_pend;
            ST_VERT: load_out = out_free && v_more && v_put && r_pend;
            ST_FIN:  load_out = out_free;
            default: load_out = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_s     <= CELL_LOG2_MIN;
            r_cfg_w     <= 5'(GRID_MAX);
            r_cfg_h     <= 5'(GRID_MAX);
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELL_LOG2: r_cfg_s <= i_cfg_data[3:0];
                    CFG_GRID_W:    r_cfg_w <= i_cfg_data;
                    CFG_GRID_H:    r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end

            r_out_valid <= load_out || (r_out_valid && i_out_stall);

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt   <= 5'd0;
                        r_steps <= 7'd0;
                        if (a_ixf == a_ixt && a_iyf == a_iyt) begin
                            // Both endpoints in one cell.
                            if ({3'd0, a_ixf} < {3'd0, gw} && {3'd0, a_iyf} < {3'd0, gh}) begin
                                r_pend <= 1'b1;
                                r_pc   <= a_ixf[3:0];
                                r_pr   <= a_iyf[3:0];
                            end
                            r_state <= ST_FIN;
                        end else if (i_in_data.start_x == i_in_data.end_x) begin
                            r_ix <= $signed({3'd0, a_ixf});
                            r_iy <= $signed({3'd0, (a_iyf < a_iyt) ? a_iyf : a_iyt});
                            r_hi <= (a_iyf < a_iyt) ? a_iyt : a_iyf;
                            r_state <= ({3'd0, a_ixf} < {3'd0, gw}) ? ST_VERT : ST_FIN;
                        end else begin
                            r_sy    <= ay;
                            r_ix    <= $signed({3'd0, swap ? a_ixt : a_ixf});
                            r_iy    <= $signed({3'd0, swap ? a_iyt : a_iyf});
                            r_ixt   <= swap ? a_ixf : a_ixt;
                            r_iyt   <= swap ? a_iyf : a_iyt;
                            r_dx    <= bx - ax;
                            r_neg   <= dy_s[16];
                            r_rem   <= 16'd0;
                            r_quo   <= {1'b0, dy_mag, 16'd0};
                            r_div_cnt <= 6'd0;
                            r_w     <= cell13 - (13'(ax) & (cell13 - 13'd1));
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem     <= q_bit ? 16'(trial - {1'b0, r_dx}) : trial[15:0];
                    r_quo     <= {r_quo[31:0], q_bit};
                    r_div_cnt <= r_div_cnt + 6'd1;
                    if (r_div_cnt == 6'd32) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    r_d     <= r_neg ? -$signed(d_mag) : $signed(d_mag);
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= {{2{prod_c[45]}}, prod_c};
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    // First crossing of the start cell's right edge, and the first cell.
                    r_yn <= $signed({16'd0, r_sy, 16'd0}) + r_prod;
                    r_ys <= ys_init;
                    r_ye <= ys_init + cext;
                    if ((r_ix < $signed({6'd0, gw})) && (r_iy < $signed({6'd0, gh}))) begin
                        r_pend <= 1'b1;
                        r_pc   <= r_ix[3:0];
                        r_pr   <= r_iy[3:0];
                        r_cnt  <= 5'd1;
                    end
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (out_free) begin
                        r_ix    <= n_ix;
                        r_iy    <= n_iy;
                        r_yn    <= n_yn;
                        r_ys    <= n_ys;
                        r_ye    <= n_ye;
                        r_steps <= n_steps;
                        r_cnt   <= n_cnt;
                        if (put_ok) begin
                            if (r_pend) begin
                                r_out <= t_cell_out'{r_pc, r_pr, 1'b1, 1'b0};
                            end
                            r_pend <= 1'b1;
                            r_pc   <= n_ix[3:0];
                            r_pr   <= n_iy[3:0];
                        end
                        if (!cont) begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_VERT: begin
                    if (out_free) begin
                        if (v_more) begin
                            if (v_put) begin
                                if (r_pend) begin
                                    r_out <= t_cell_out'{r_pc, r_pr, 1'b1, 1'b0};
                                end
                                r_pend <= 1'b1;
                                r_pc   <= r_ix[3:0];
                                r_pr   <= r_iy[3:0];
                                r_cnt  <= r_cnt + 5'd1;
                            end
                            r_iy <= r_iy + 11'sd1;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    // The held cell goes out with last set, or a miss beat if none was found.
                    if (out_free) begin
                        r_out   <= r_pend ? t_cell_out'{r_pc, r_pr, 1'b1, 1'b1}
                                          : t_cell_out'{4'd0, 4'd0, 1'b0, 1'b1};
                        r_pend  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/segw_check.sv
// Port-level checker for the segment grid cell walk and its bind statement.
module segw_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [1:0]          i_cfg_idx,
    input logic [4:0]          i_cfg_data,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input segw_pkg::t_seg_in   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input segw_pkg::t_cell_out o_out_data
);
    import segw_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |-> o_out_data.last)
        else $error("miss beat without last");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the segment finished");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

endmodule

bind segment_grid_cell_walk segw_check u_segw_check (.*);
